@@ rtl/core/rsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rsfc_pkg: shared types and constants for the record sector fixup checker
// Holds the header signature, the sector size limits, the status codes and
// the output bus layout.
// ----------------------------------------------------------------------------
package rsfc_pkg;

	// Width of one record word.
	localparam int unsigned WORD_W = 16;
	// Width of the sector size register.
	localparam int unsigned WPS_W = 12;
	// Width of the in-sector word counter.
	localparam int unsigned SWC_W = 11;
	// Width of the entry offset in words.
	localparam int unsigned OFS_W = WORD_W - 1;
	// Output data bus width: word, status, warning, padded to whole bytes.
	localparam int unsigned TDATA_W = 24;

	// Defaults for the top level parameters.
	localparam int unsigned DEF_MAX_ARRAY_ENTRIES = 16;
	localparam int unsigned DEF_MAX_RECORD_WORDS = 2048;

	// The four signature bytes, read as two little-endian words.
	localparam logic [WORD_W-1:0] SIG_LO = 16'h4946;
	localparam logic [WORD_W-1:0] SIG_HI = 16'h454C;

	// A record must hold at least the full header.
	localparam int unsigned HEADER_WORDS = 8;

	// Sector size limits and reset value, in words.
	localparam logic [WPS_W-1:0] WPS_MIN = 12'd128;
	localparam logic [WPS_W-1:0] WPS_MAX = 12'd2048;
	localparam logic [WPS_W-1:0] WPS_RESET = 12'd256;

	// Record status codes, reported on the final word.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_SIG      = 3'd2,
		ST_HEADER   = 3'd3,
		ST_MISMATCH = 3'd4,
		ST_UNSEEN   = 3'd5,
		ST_LONG     = 3'd6
	} status_t;

	// Bring a written sector size into the supported range.
	function automatic logic [WPS_W-1:0] clamp_wps(input logic [WPS_W-1:0] v);
		logic [WPS_W-1:0] r;
		r = v;
		if (v < WPS_MIN) r = WPS_MIN;
		if (v > WPS_MAX) r = WPS_MAX;
		return r;
	endfunction

endpackage

@@ rtl/core/rsfc_entry_store.sv @@
// ----------------------------------------------------------------------------
// rsfc_entry_store: update-sequence entry memory
// One write port and one registered read port. A read that hits the entry
// written in the same cycle is flagged so the caller can take the new word.
// ----------------------------------------------------------------------------
module rsfc_entry_store
	import rsfc_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_MAX_ARRAY_ENTRIES,
	parameter int unsigned IDX_W = $clog2(DEF_MAX_ARRAY_ENTRIES)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [WORD_W-1:0] rd_data,
	output logic              rd_hit
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_hit_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// Registered read port with a same-cycle write hit flag.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
			rd_hit_q  <= wr_en && (wr_idx == rd_idx);
		end
	end

	assign rd_data = rd_data_q;
	assign rd_hit  = rd_hit_q;

endmodule

@@ rtl/core/record_sector_fixup_check.sv @@
// ----------------------------------------------------------------------------
// record_sector_fixup_check: file-table record sector fixup and check
// Takes a record as a stream of little-endian 16-bit words, one per request,
// with tlast on the final word. It checks the FILE signature, reads the
// update-sequence offset and count from words 2 and 3, captures the entries
// as they pass, and at the last word of each sector compares that word with
// entry 0 and puts entry k in its place (tuser marks a replaced word). On the
// final word it reports a sticky status and a beyond-record warning. The block
// takes one word per clock, sustained while m_axis_tready does not stall the
// output. The checks run on the input register, the registered read port of
// the entry memory lands entry k in a second register beside the checked word,
// and the output register holds the result. No clearing pass is needed after
// reset. The sector size register is written by cfg_we and cfg_wdata; the user
// must write it only while no record is in flight, the block does not enforce
// it. Values outside 128 to 2048 words are clamped.
// ----------------------------------------------------------------------------
module record_sector_fixup_check
	import rsfc_pkg::*;
#(
	parameter int unsigned MAX_ARRAY_ENTRIES = DEF_MAX_ARRAY_ENTRIES,
	parameter int unsigned MAX_RECORD_WORDS = DEF_MAX_RECORD_WORDS
) (
	input  logic               clk,
	input  logic               arst_n,
	// Sector size register, in words.
	input  logic               cfg_we,
	input  logic [WPS_W-1:0]   cfg_wdata,
	// Record words in.
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [WORD_W-1:0]  s_axis_tdata,   // [15:0] record_word
	input  logic               s_axis_tlast,   // last_word
	// Fixed words out.
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // [15:0] fixed_word, [18:16] status,
	                                           // [19] beyond_record_warning, [23:20] zero
	output logic               m_axis_tuser,   // was_replaced
	output logic               m_axis_tlast    // is_last
);

	localparam int unsigned CW = $clog2(MAX_ARRAY_ENTRIES + 1);
	localparam int unsigned IW = $clog2(MAX_ARRAY_ENTRIES);
	localparam int unsigned PW = $clog2(MAX_RECORD_WORDS + 1);
	localparam int unsigned DW = ((PW > OFS_W) ? PW : OFS_W) + 1;
	localparam int unsigned RW = PW + 1;
	localparam int unsigned MW = CW + WPS_W;
	localparam int unsigned XW = (MW > RW) ? MW : RW;
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_RECORD_WORDS);
	localparam logic [CW-1:0] SEC_SAT = {CW{1'b1}};

	// Handshake and stage control.
	logic v1_s1, v2_s2, vo_q;
	logic rdy_o, rdy2, rdy1, adv1, adv2, in_acc;

	// Stage 1 payload.
	logic [WORD_W-1:0] word_s1;
	logic              last_s1;

	// Record state.
	logic [WPS_W-1:0]             wps_q;
	logic [PW-1:0]                pos_q;
	logic [SWC_W-1:0]             swc_q;
	logic [CW-1:0]                sec_q;
	logic [OFS_W-1:0]             ofs_q;
	logic [CW-1:0]                cnt_q;
	logic [MAX_ARRAY_ENTRIES-1:0] seen_q;
	status_t                      st_q;
	logic [WORD_W-1:0]            ent0_q;

	// Stage 1 decisions.
	status_t                      st_b, st_c, st_out;
	logic [CW-1:0]                cnt_n;
	logic [OFS_W-1:0]             ofs_n;
	logic                         cap, swc_end, repl, short_rec, warn;
	logic [DW-1:0]                diff;
	logic [IW-1:0]                e_idx, k_idx;
	logic [CW:0]                  k;
	logic [MAX_ARRAY_ENTRIES-1:0] seen_eff;
	logic [WORD_W-1:0]            ent0_eff;
	logic [RW-1:0]                received;
	logic [MW-1:0]                span;

	// Stage 2 payload.
	logic [WORD_W-1:0] word_s2;
	logic              last_s2, repl_s2, warn_s2;
	status_t           status_s2;
	logic [WORD_W-1:0] ent_rd;
	logic              ent_hit;
	logic [WORD_W-1:0] fixed_word;

	// Output register.
	logic [TDATA_W-1:0] data_q;
	logic               user_q, last_q;

	// Ready flows back stage by stage; each stage moves when the next has room.
	assign rdy_o  = !vo_q || m_axis_tready;
	assign rdy2   = !v2_s2 || rdy_o;
	assign rdy1   = !v1_s1 || rdy2;
	assign adv2   = v2_s2 && rdy_o;
	assign adv1   = v1_s1 && rdy2;
	assign in_acc = s_axis_tvalid && rdy1;
	assign s_axis_tready = rdy1;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			vo_q  <= 1'b0;
		end else begin
			if (in_acc) v1_s1 <= 1'b1;
			else if (adv1) v1_s1 <= 1'b0;
			if (adv1) v2_s2 <= 1'b1;
			else if (adv2) v2_s2 <= 1'b0;
			if (adv2) vo_q <= 1'b1;
			else if (m_axis_tready) vo_q <= 1'b0;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Header decode, entry capture and sector-end check for the word in stage 1.
	always_comb begin
		status_t st_a;
		st_a = st_q;
		if (pos_q >= POS_MAX && st_a == ST_OK) st_a = ST_LONG;

		st_b  = st_a;
		cnt_n = cnt_q;
		ofs_n = ofs_q;
		cap   = 1'b0;
		diff  = DW'(pos_q) - DW'(ofs_q);
		e_idx = diff[IW-1:0];

		if (pos_q == PW'(0)) begin
			if (word_s1 != SIG_LO && st_b == ST_OK) st_b = ST_SIG;
		end else if (pos_q == PW'(1)) begin
			if (word_s1 != SIG_HI && st_b == ST_OK) st_b = ST_SIG;
		end else if (pos_q == PW'(2)) begin
			ofs_n = word_s1[WORD_W-1:1];
			if (word_s1[0] && st_b == ST_OK) st_b = ST_HEADER;
		end else if (pos_q == PW'(3)) begin
			if (word_s1 > WORD_W'(MAX_ARRAY_ENTRIES)) begin
				if (st_b == ST_OK) st_b = ST_HEADER;
			end else if (st_b == ST_OK) begin
				cnt_n = word_s1[CW-1:0];
			end
		end else begin
			cap = (DW'(pos_q) >= DW'(ofs_q)) && (diff < DW'(cnt_q));
		end

		// The entry captured by this word is visible to its own check.
		seen_eff = seen_q;
		ent0_eff = ent0_q;
		if (cap) begin
			seen_eff[e_idx] = 1'b1;
			if (e_idx == IW'(0)) ent0_eff = word_s1;
		end

		// Sector end: compare with entry 0 and replace with entry k.
		swc_end = ({1'b0, swc_q} + 12'd1) >= wps_q;
		k       = {1'b0, sec_q} + (CW+1)'(1);
		k_idx   = k[IW-1:0];
		repl    = 1'b0;
		st_c    = st_b;
		if (swc_end && st_b == ST_OK && k < {1'b0, cnt_n}) begin
			if (!seen_eff[0] || !seen_eff[k_idx]) begin
				st_c = ST_UNSEEN;
			end else if (word_s1 != ent0_eff) begin
				st_c = ST_MISMATCH;
			end else begin
				repl = 1'b1;
			end
		end

		// Final word report.
		received  = RW'(pos_q) + RW'(1);
		short_rec = received < RW'(HEADER_WORDS);
		span      = MW'(cnt_n - CW'(1)) * MW'(wps_q);
		warn      = last_s1 && (cnt_n >= CW'(2)) && (XW'(span) > XW'(received));
		st_out    = ST_OK;
		if (last_s1) st_out = short_rec ? ST_SHORT : st_c;
	end

	// Sector size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wps_q <= WPS_RESET;
		end else if (cfg_we) begin
			wps_q <= clamp_wps(cfg_wdata);
		end
	end

	// Record state; everything clears after the final word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			swc_q  <= '0;
			sec_q  <= '0;
			ofs_q  <= '0;
			cnt_q  <= '0;
			seen_q <= '0;
			st_q   <= ST_OK;
		end else if (adv1) begin
			if (last_s1) begin
				pos_q  <= '0;
				swc_q  <= '0;
				sec_q  <= '0;
				ofs_q  <= '0;
				cnt_q  <= '0;
				seen_q <= '0;
				st_q   <= ST_OK;
			end else begin
				if (pos_q < POS_MAX) pos_q <= pos_q + PW'(1);
				if (swc_end) begin
					swc_q <= '0;
					if (sec_q != SEC_SAT) sec_q <= sec_q + CW'(1);
				end else begin
					swc_q <= swc_q + SWC_W'(1);
				end
				ofs_q  <= ofs_n;
				cnt_q  <= cnt_n;
				seen_q <= seen_eff;
				st_q   <= st_c;
			end
		end
	end

	// Copy of entry 0 for the sector-end compare.
	always_ff @(posedge clk) begin
		if (adv1) begin
			ent0_q <= ent0_eff;
		end
	end

	// Entry memory: captured words go in, entry k is read for stage 2.
	rsfc_entry_store #(
		.DEPTH (MAX_ARRAY_ENTRIES),
		.IDX_W (IW)
	) u_store (
		.clk     (clk),
		.wr_en   (adv1 && cap),
		.wr_idx  (e_idx),
		.wr_data (word_s1),
		.rd_en   (adv1),
		.rd_idx  (k_idx),
		.rd_data (ent_rd),
		.rd_hit  (ent_hit)
	);

	// Stage 2 register.
	always_ff @(posedge clk) begin
		if (adv1) begin
			word_s2   <= word_s1;
			last_s2   <= last_s1;
			repl_s2   <= repl;
			status_s2 <= st_out;
			warn_s2   <= warn;
		end
	end

	// A replacing entry written by this same word is the word itself.
	assign fixed_word = repl_s2 ? (ent_hit ? word_s2 : ent_rd) : word_s2;

	// Output register.
	always_ff @(posedge clk) begin
		if (adv2) begin
			data_q <= {4'b0000, warn_s2, status_s2, fixed_word};
			user_q <= repl_s2;
			last_q <= last_s2;
		end
	end

	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;
	assign m_axis_tlast  = last_q;

endmodule

@@ rtl/core/rsfc_checker.sv @@
// ----------------------------------------------------------------------------
// rsfc_checker: port-level checks for the record sector fixup checker
// Watches the result stream for report fields outside the final word, for
// replaced words with a bad status, and for a stalled result that moves.
// ----------------------------------------------------------------------------
module rsfc_checker
	import rsfc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic               m_axis_tuser,
	input logic               m_axis_tlast
);

	// Status and warning are only reported on the final word of a record.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[19:16] == 4'b0000)
		else $error("report fields set on a word that is not the last");

	// A replaced word can only come from a record that is still clean.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[18:16] == ST_OK)
		else $error("replaced word carries an error status");

	// Status code is a known one and the padding stays clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[18:16] <= ST_LONG && m_axis_tdata[23:20] == 4'b0000)
		else $error("bad status code or padding on result");

	// A stalled result holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind record_sector_fixup_check rsfc_checker u_rsfc_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for record_sector_fixup_check
// Streams file-table records into the block and predicts every fixed word,
// replace flag, status and warning. A short opening set covers a short
// record, a bad signature, an odd offset and the count warning. Then a long
// record covers a sector size change inside a record. Random records follow
// at several sector sizes, from 0 to 4095, mostly well formed with some
// broken ones. Both sides idle at random, and the receiver stalls once for a
// long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
	import rsfc_pkg::*;

	localparam int unsigned MAX_ENT = DEF_MAX_ARRAY_ENTRIES;
	localparam int unsigned MAX_REC = DEF_MAX_RECORD_WORDS;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned PHASE_WORDS = 80;

	// One word going in, and what must come out for it.
	typedef struct packed {
		logic              last;
		logic [WORD_W-1:0] word;
	} rec_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              replaced;
		logic              last;
		status_t           status;
		logic              warn;
	} fixed_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [WPS_W-1:0]   cfg_wdata = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [WORD_W-1:0]  s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;
	logic               m_axis_tlast;

	record_sector_fixup_check uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Pending words, expected results and run bookkeeping.
	rec_word_t         word_queue[$];
	fixed_word_t       expected_words[$];
	logic [WORD_W-1:0] rec_buf [0:4095];
	logic [WORD_W-1:0] check_word;
	int unsigned       words_queued = 0;
	int unsigned       words_accepted = 0;
	int unsigned       results_checked = 0;
	int unsigned       error_count = 0;
	int unsigned       records_done = 0;
	int unsigned       replaced_total = 0;
	int unsigned       status_tally [0:7];
	bit                tx_idle_on = 1'b1;
	bit                rx_idle_on = 1'b1;

	// Predictor state: register copy and per-record context.
	logic [WPS_W-1:0]   wps_reg = WPS_RESET;
	int unsigned        rec_pos;
	int unsigned        sec_pos;
	int unsigned        sec_index;
	int unsigned        usa_offset;
	int unsigned        usa_count;
	logic [WORD_W-1:0]  usa_entry [0:MAX_ENT-1];
	logic [MAX_ENT-1:0] usa_seen;
	status_t            rec_status;

	// Effective sector length in words for a written register value.
	function automatic int unsigned sector_words(input logic [WPS_W-1:0] v);
		if (v < WPS_MIN) return 32'(WPS_MIN);
		if (v > WPS_MAX) return 32'(WPS_MAX);
		return 32'(v);
	endfunction

	function automatic void start_record();
		rec_pos = 0;
		sec_pos = 0;
		sec_index = 0;
		usa_offset = 0;
		usa_count = 0;
		usa_seen = '0;
		rec_status = ST_OK;
		for (int i = 0; i < MAX_ENT; i++) usa_entry[i] = '0;
	endfunction

	// Only the first error of a record is kept.
	function automatic void first_error(input status_t code);
		if (rec_status == ST_OK) rec_status = code;
	endfunction

	// Work out the result for one record word and advance the record context.
	function automatic fixed_word_t fixup_word(input logic [WORD_W-1:0] w, input logic last);
		fixed_word_t r;
		int unsigned wps, p, k, e, rcvd;
		wps = sector_words(wps_reg);
		p = rec_pos;
		r.word = w;
		r.replaced = 1'b0;
		r.last = last;
		r.status = ST_OK;
		r.warn = 1'b0;

		if (p >= MAX_REC) first_error(ST_LONG);

		// Header words, then entry capture.
		if (p == 0) begin
			if (w != SIG_LO) first_error(ST_SIG);
		end else if (p == 1) begin
			if (w != SIG_HI) first_error(ST_SIG);
		end else if (p == 2) begin
			usa_offset = 32'(w >> 1);
			if (w[0]) first_error(ST_HEADER);
		end else if (p == 3) begin
			if (w > MAX_ENT) first_error(ST_HEADER);
			else if (rec_status == ST_OK) usa_count = 32'(w);
		end else if (p >= usa_offset && p - usa_offset < usa_count) begin
			e = p - usa_offset;
			usa_entry[e] = w;
			usa_seen[e] = 1'b1;
		end

		// Sector end: check against entry 0 and put entry k in its place.
		if (sec_pos + 1 >= wps) begin
			k = sec_index + 1;
			if (rec_status == ST_OK && k < usa_count) begin
				if (!usa_seen[0] || !usa_seen[k]) begin
					first_error(ST_UNSEEN);
				end else if (w != usa_entry[0]) begin
					first_error(ST_MISMATCH);
				end else begin
					r.word = usa_entry[k];
					r.replaced = 1'b1;
				end
			end
			sec_pos = 0;
			if (sec_index < 16'hFFFF) sec_index++;
		end else begin
			sec_pos++;
		end

		if (rec_pos < MAX_REC) rec_pos++;

		// Final word: report status and warning, then clear for the next record.
		if (last) begin
			rcvd = p + 1;
			r.status = rec_status;
			if (rcvd < HEADER_WORDS) r.status = ST_SHORT;
			if (usa_count >= 2 && (usa_count - 1) * wps > rcvd) r.warn = 1'b1;
			start_record();
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		if (error_count < 40)
			$display("Mismatch on result %0d: %s is %h, expected %h",
				results_checked, field, got, want);
		error_count++;
	endtask

	// Sender: presents queued words, predicts each one when its request is taken.
	rec_word_t   next_word;
	fixed_word_t predicted;
	int unsigned tx_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted = fixup_word(s_axis_tdata, s_axis_tlast);
				expected_words.push_back(predicted);
				words_accepted++;
				if (predicted.replaced) replaced_total++;
				if (predicted.last) begin
					records_done++;
					status_tally[predicted.status]++;
				end
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (word_queue.size() != 0) begin
					next_word = word_queue.pop_front();
					s_axis_tdata <= next_word.word;
					s_axis_tlast <= next_word.last;
					s_axis_tvalid <= 1'b1;
					tx_gap <= tx_idle_on ? $urandom_range(0, 3) : 0;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result against the oldest expectation and stalls.
	fixed_word_t wanted;
	int unsigned rx_wait;
	bit          hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected fixed_word",
						32'(m_axis_tdata[15:0]), 0);
				end else begin
					wanted = expected_words.pop_front();
					if (m_axis_tdata[15:0] !== wanted.word)
						report_mismatch("fixed_word",
							32'(m_axis_tdata[15:0]), 32'(wanted.word));
					if (m_axis_tuser !== wanted.replaced)
						report_mismatch("was_replaced",
							32'(m_axis_tuser), 32'(wanted.replaced));
					if (m_axis_tlast !== wanted.last)
						report_mismatch("is_last",
							32'(m_axis_tlast), 32'(wanted.last));
					if (m_axis_tdata[18:16] !== wanted.status)
						report_mismatch("status",
							32'(m_axis_tdata[18:16]), 32'(wanted.status));
					if (m_axis_tdata[19] !== wanted.warn)
						report_mismatch("beyond_record_warning",
							32'(m_axis_tdata[19]), 32'(wanted.warn));
				end
				results_checked++;
				rx_wait = rx_idle_on ? $urandom_range(0, 3) : 0;
			end
			// One long hold-off while the sender still has plenty to offer.
			if (!hold_done && results_checked >= 1000 && word_queue.size() > 40) begin
				rx_wait = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (rx_wait != 0) begin
				m_axis_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no request moves on either side for too long.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no request moved for %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_word(input logic [WORD_W-1:0] w, input logic last);
		word_queue.push_back({last, w});
		words_queued++;
	endtask

	task automatic queue_words(input int unsigned first, input int unsigned n,
			input bit ends_record);
		for (int i = 0; i < n; i++)
			push_word(rec_buf[first + i], ends_record && (i == n - 1));
	endtask

	// Build a record in rec_buf: random body, entries, sector ends, header.
	task automatic fill_record(input int unsigned len, input int unsigned ofs_w,
			input int unsigned cnt, input int unsigned spacing);
		check_word = WORD_W'($urandom);
		for (int i = 0; i < len; i++) rec_buf[i] = WORD_W'($urandom);
		for (int e = 0; e < cnt; e++)
			if (ofs_w + e < len) rec_buf[ofs_w + e] = (e == 0) ? check_word : WORD_W'($urandom);
		for (int i = spacing - 1; i < len; i += spacing)
			rec_buf[i] = ($urandom_range(0, 15) == 0) ? WORD_W'($urandom) : check_word;
		rec_buf[0] = SIG_LO;
		rec_buf[1] = SIG_HI;
		rec_buf[2] = WORD_W'(ofs_w * 2);
		rec_buf[3] = WORD_W'(cnt);
	endtask

	// Mostly well-formed records; the rest carry one kind of fault or noise.
	task automatic queue_random_record(input int unsigned spacing, output int unsigned len);
		int unsigned kind, cnt, ofs_w, nsec;
		kind = $urandom_range(0, 9);
		cnt = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 4) : $urandom_range(0, MAX_ENT);
		ofs_w = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(4, 12);
		// Entry 0 hidden behind the header, or entries placed after a sector end.
		if (kind == 9) begin
			if ($urandom_range(0, 1)) ofs_w = $urandom_range(0, 3);
			else ofs_w = spacing + $urandom_range(0, 20);
		end
		if (cnt >= 2 && spacing <= 300 && $urandom_range(0, 1)) begin
			nsec = $urandom_range(1, (cnt > 2) ? 2 : 1);
			len = nsec * spacing + $urandom_range(0, 10);
		end else begin
			len = $urandom_range(8, 48);
		end
		if (kind == 9 && $urandom_range(0, 2) == 0) len = $urandom_range(1, 7);
		fill_record(len, ofs_w, cnt, spacing);
		case (kind)
			6: for (int i = 0; i < 4; i++) rec_buf[i] = WORD_W'($urandom);
			7: rec_buf[$urandom_range(0, 1)] ^= WORD_W'(1) << $urandom_range(0, 15);
			8: begin
				if ($urandom_range(0, 1)) rec_buf[2][0] = 1'b1;
				else rec_buf[3] = WORD_W'($urandom_range(MAX_ENT + 1, 16'hFFFF));
			end
			default: ;
		endcase
		queue_words(0, len, 1'b1);
	endtask

	// Idle means every queued word was taken and every result came back.
	task automatic wait_for_drain();
		do @(posedge clk);
		while (words_accepted != words_queued || expected_words.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sector_size(input logic [WPS_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		wps_reg = v;
	endtask

	// Stimulus sequence.
	logic [WORD_W-1:0] opening [0:26];
	logic [WPS_W-1:0]  size_list [0:6];
	int unsigned       phase_words;
	int unsigned       rec_len;

	initial begin
		start_record();
		for (int i = 0; i < 8; i++) status_tally[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Opening records: too short, bad signature, odd offset, full count
		// that runs past the record.
		opening = '{
			16'hFFFF, 16'h0000, 16'hFFFF,
			SIG_LO, 16'hFFFF, 16'h0010, 16'h0002, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
			SIG_LO, SIG_HI, 16'hFFFF, 16'h0010, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			SIG_LO, SIG_HI, 16'h0008, WORD_W'(MAX_ENT), 16'h0000, 16'hFFFF, 16'h8001,
			16'h7FFE
		};
		for (int i = 0; i < 27; i++)
			push_word(opening[i], i == 2 || i == 10 || i == 18 || i == 26);
		wait_for_drain();

		// Sector size shrinks inside a record: the counter already past the
		// new end makes the next word a sector end.
		write_sector_size(12'd512);
		fill_record(560, 8, 3, 4096);
		rec_buf[300] = check_word;
		rec_buf[556] = check_word;
		queue_words(0, 300, 1'b0);
		wait_for_drain();
		write_sector_size(12'd256);
		queue_words(300, 260, 1'b1);
		wait_for_drain();

		// Random records at a spread of sector sizes, clamped ones included.
		size_list = '{12'd128, 12'd0, 12'd200, 12'd4095, 12'd256, 12'd2049, 12'd127};
		for (int ph = 0; ph < 7; ph++) begin
			write_sector_size(size_list[ph]);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				queue_random_record(sector_words(size_list[ph]), rec_len);
				phase_words += rec_len;
			end
			wait_for_drain();
		end
		repeat (6) @(posedge clk);

		$display("Run covered %0d words in %0d records, sector sizes from 0 to 4095,",
			words_accepted, records_done);
		$display("%0d sector ends replaced; outcomes ok %0d, short %0d, signature %0d,",
			replaced_total, status_tally[ST_OK], status_tally[ST_SHORT],
			status_tally[ST_SIG]);
		$display("header %0d, mismatch %0d, unseen %0d, long %0d.",
			status_tally[ST_HEADER], status_tally[ST_MISMATCH], status_tally[ST_UNSEEN],
			status_tally[ST_LONG]);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
